// ===== hdl/b32c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32c_pkg
// Shared types, mode codes and alphabet helpers for the bech32 data codec.
// ----------------------------------------------------------------------------
package b32c_pkg;

  localparam logic [1:0] MODE_ENC      = 2'd0;
  localparam logic [1:0] MODE_DEC_BYTE = 2'd1;
  localparam logic [1:0] MODE_DEC_SYM  = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam int unsigned MAX_RES           = 3;
  localparam int unsigned RES_CNT_W         = $clog2(MAX_RES + 1);
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;
  localparam int unsigned NUM_SYM           = 32;

  localparam logic [7:0] ALPHABET [NUM_SYM] = '{
    "q", "p", "z", "r", "y", "9", "x", "8",
    "g", "f", "2", "t", "v", "d", "w", "0",
    "s", "3", "j", "n", "5", "4", "k", "h",
    "c", "e", "6", "m", "u", "a", "7", "l"
  };

  typedef struct packed {
    logic [7:0] value;
    logic       has_value;
    logic       bad_char;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]   res;
    logic [RES_CNT_W-1:0] cnt;
  } entry_t;

  function automatic logic [7:0] sym_to_char(input logic [4:0] sym);
    return ALPHABET[sym];
  endfunction

  // {unknown, symbol}
  function automatic logic [5:0] char_to_sym(input logic [7:0] c);
    logic [5:0] r;
    r = 6'b10_0000;
    for (int i = 0; i < NUM_SYM; i++) begin
      if (c == ALPHABET[i]) begin
        r = {1'b0, 5'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/b32c_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32c_if
// Valid/ready channels for codec input items and result items.
// ----------------------------------------------------------------------------
interface b32c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_value;
  logic       in_last;

  modport source (output valid, in_value, in_last, input ready);
  modport sink   (input valid, in_value, in_last, output ready);
endinterface

interface b32c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic       has_value;
  logic       bad_char;
  logic       out_last;

  modport source (output valid, out_value, has_value, bad_char, out_last, input ready);
  modport sink   (input valid, out_value, has_value, bad_char, out_last, output ready);
endinterface

// ===== hdl/b32c_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32c_front
// Accepts input beats, tracks pending bits and builds the result group.
// ----------------------------------------------------------------------------
module b32c_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  b32c_in_if.sink           in_ch,
  output logic              push,
  output b32c_pkg::entry_t  push_entry,
  input  logic              q_full
);

  logic [1:0] mode_r;
  logic [7:0] store_r, store_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       err_r, err_nxt;
  logic       accept;

  b32c_pkg::res_t [b32c_pkg::MAX_RES-1:0] res_list;
  logic [b32c_pkg::RES_CNT_W-1:0]         n;

  function automatic b32c_pkg::res_t make_res(input logic [7:0] v, input logic has,
                                              input logic bad, input logic lst);
    b32c_pkg::res_t r;
    r.value     = v;
    r.has_value = has;
    r.bad_char  = bad;
    r.last      = lst;
    return r;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin : calc
    logic [11:0] acc;
    logic [3:0]  total;
    logic [3:0]  rem;
    logic [5:0]  look;
    logic        err_now;
    store_nxt = store_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    n         = '0;
    res_list  = '0;
    acc       = '0;
    total     = '0;
    rem       = '0;
    err_now   = err_r;
    look      = b32c_pkg::char_to_sym(in_ch.in_value);
    case (mode_r)
      b32c_pkg::MODE_ENC: begin
        acc   = {store_r[3:0], in_ch.in_value};
        total = {1'b0, cnt_r} + 4'd8;
        res_list[0] = make_res(b32c_pkg::sym_to_char(5'(acc >> (total - 4'd5))),
                               1'b1, 1'b0, 1'b0);
        if (total >= 4'd10) begin
          res_list[1] = make_res(b32c_pkg::sym_to_char(5'(acc >> (total - 4'd10))),
                                 1'b1, 1'b0, 1'b0);
          n   = 2'd2;
          rem = total - 4'd10;
        end else begin
          n   = 2'd1;
          rem = total - 4'd5;
        end
        // zero-pad the leftover bits into a final character
        if (in_ch.in_last && rem != 4'd0) begin
          res_list[n] = make_res(b32c_pkg::sym_to_char(5'(acc[4:0] << (3'd5 - rem[2:0]))),
                                 1'b1, 1'b0, 1'b0);
          n = n + 2'd1;
        end
        store_nxt = 8'(acc & ((12'd1 << rem) - 12'd1));
        cnt_nxt   = rem[2:0];
      end
      b32c_pkg::MODE_DEC_BYTE, b32c_pkg::MODE_DEC_SYM: begin
        err_now = err_r | look[5];
        err_nxt = err_now;
        if (err_now) begin
          if (in_ch.in_last) begin
            res_list[0] = make_res(8'd0, 1'b0, 1'b1, 1'b0);
            n = 2'd1;
          end
        end else if (mode_r == b32c_pkg::MODE_DEC_SYM) begin
          res_list[0] = make_res({3'd0, look[4:0]}, 1'b1, 1'b0, 1'b0);
          n = 2'd1;
        end else begin
          acc   = {store_r[6:0], look[4:0]};
          total = {1'b0, cnt_r} + 4'd5;
          if (total >= 4'd8) begin
            res_list[0] = make_res(8'(acc >> (total - 4'd8)), 1'b1, 1'b0, 1'b0);
            n   = 2'd1;
            rem = total - 4'd8;
          end else begin
            rem = total;
          end
          store_nxt = 8'(acc & ((12'd1 << rem) - 12'd1));
          cnt_nxt   = rem[2:0];
          if (in_ch.in_last && n == 2'd0) begin
            res_list[0] = make_res(8'd0, 1'b0, 1'b0, 1'b0);
            n = 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (in_ch.in_last && mode_r != b32c_pkg::MODE_NONE) begin
      if (n != 2'd0) begin
        res_list[n - 2'd1].last = 1'b1;
      end
      store_nxt = '0;
      cnt_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  assign push           = accept && (n != '0);
  assign push_entry.res = res_list;
  assign push_entry.cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= b32c_pkg::MODE_ENC;
      store_r <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      // a mode write starts a fresh message
      mode_r  <= cfg_wr_data;
      store_r <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      store_r <= store_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== hdl/b32c_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32c_queue
// Short FIFO of result groups between the front and back parts.
// ----------------------------------------------------------------------------
module b32c_queue #(
  parameter int unsigned DEPTH = b32c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b32c_pkg::entry_t  push_entry,
  output logic              full,
  output logic              head_valid,
  output b32c_pkg::entry_t  head_entry,
  input  logic              pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b32c_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/b32c_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32c_back
// Drains the head result group one output beat per cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
module b32c_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  b32c_pkg::entry_t  head_entry,
  output logic              pop,
  b32c_out_if.source        out_ch
);

  logic [b32c_pkg::RES_CNT_W-1:0] idx_r;
  logic                           accept;
  logic                           at_end;
  b32c_pkg::res_t                 cur;

  assign cur              = head_entry.res[idx_r];
  assign out_ch.valid     = head_valid;
  assign out_ch.out_value = cur.value;
  assign out_ch.has_value = cur.has_value;
  assign out_ch.bad_char  = cur.bad_char;
  assign out_ch.out_last  = cur.last;

  assign accept = out_ch.valid && out_ch.ready;
  assign at_end = (idx_r == head_entry.cnt - 1'b1);
  assign pop    = accept && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (accept) begin
      // advance within the group, drop it after its last beat
      idx_r <= at_end ? '0 : idx_r + 1'b1;
    end
  end

endmodule

// ===== hdl/base32_bech32_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_bech32_codec
// Streaming bech32 data-part codec: encode bytes, decode to bytes or symbols.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        in_value[7:0], in_last
//  out_ch   out  valid/ready        out_value[7:0], has_value, bad_char, out_last
//  cfg      in   cfg_wr_en (write)  cfg_wr_data[1:0] = mode
//
//  An input beat is taken every cycle while the group queue has room; each
//  beat yields zero to three results, and the back part drives one result
//  beat per cycle while out_ch.ready is high, so the result side sets the
//  sustained rate. Reset (rst_n, synchronous) selects encode mode and
//  empties the queue. An output stall fills the QUEUE_DEPTH-entry queue,
//  after which in_ch.ready drops.
// ----------------------------------------------------------------------------
module base32_bech32_codec #(
  parameter int unsigned QUEUE_DEPTH = b32c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  b32c_in_if.sink     in_ch,
  b32c_out_if.source  out_ch
);

  logic              push;
  logic              full;
  logic              head_valid;
  logic              pop;
  b32c_pkg::entry_t  push_entry;
  b32c_pkg::entry_t  head_entry;

  b32c_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (full)
  );

  b32c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  b32c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
